// ===== hw/rtl/rtcprr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP receiver report parser package
// Shared constants, codes and the result record of the report parser.
// ----------------------------------------------------------------------------
package rtcprr_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 2048;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_HDR,
    MODE_BODY,
    MODE_STOP
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_VERSION = 2'd1,
    ST_SHORT   = 2'd2,
    ST_TYPE    = 2'd3
  } status_t;

  localparam logic [7:0] TYPE_SR   = 8'd200;
  localparam logic [7:0] TYPE_RR   = 8'd201;
  localparam logic [7:0] TYPE_SDES = 8'd202;
  localparam logic [7:0] TYPE_BYE  = 8'd203;

  localparam logic [1:0] RTP_VERSION = 2'd2;

  localparam logic KIND_BLOCK  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [31:0] reporter_ssrc;
    logic [31:0] source_ssrc;
    logic [7:0]  loss_fraction;
    logic [23:0] cumulative_lost;
    logic [31:0] highest_seq;
    logic [31:0] jitter;
    logic [31:0] last_sr;
    logic [31:0] delay_since_sr;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rtcp_byte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP byte channel
// Valid/ready channel carrying one datagram byte per beat.
// ----------------------------------------------------------------------------
interface rtcp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [11:0] packet_len;

  modport source (output valid, output data_byte, output first_byte, output packet_len,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input packet_len,
                output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rtcp_report_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP report channel
// Valid/ready channel carrying one report block or status result per beat.
// ----------------------------------------------------------------------------
interface rtcp_report_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [31:0] reporter_ssrc;
  logic [31:0] source_ssrc;
  logic [7:0]  loss_fraction;
  logic [23:0] cumulative_lost;
  logic [31:0] highest_seq;
  logic [31:0] jitter;
  logic [31:0] last_sr;
  logic [31:0] delay_since_sr;

  modport source (output valid, output kind, output status, output reporter_ssrc,
                  output source_ssrc, output loss_fraction, output cumulative_lost,
                  output highest_seq, output jitter, output last_sr,
                  output delay_since_sr, input ready);
  modport sink (input valid, input kind, input status, input reporter_ssrc,
                input source_ssrc, input loss_fraction, input cumulative_lost,
                input highest_seq, input jitter, input last_sr,
                input delay_since_sr, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rtcp_receiver_report_parser.sv =====
`default_nettype none
// Each result is registered into the result queue and offered from its head.
// Throughput: one byte beat per cycle; a byte that ends both a report block and
// the datagram queues two results. Input ready drops while the four-entry result
// queue has fewer than two free entries.
// Reset (synchronous) returns the parser to idle and empties the result queue.
// ----------------------------------------------------------------------------
// RTCP receiver report parser
// Walks an RTCP compound datagram byte by byte, emits one result per receiver
// report block and one status result at the end of each datagram.
// ----------------------------------------------------------------------------
module rtcp_receiver_report_parser (
  input  logic                 clk,
  input  logic                 rst,
  rtcp_byte_if.sink            pkt,
  rtcp_report_if.source        rpt
);
  import rtcprr_pkg::*;

  mode_t       mode, mode_next;
  status_t     stop, stop_next;
  logic [11:0] left, left_next;
  logic [18:0] bis, bis_next;
  logic [18:0] splen, splen_next;
  logic [7:0]  sptype, sptype_next;
  logic [4:0]  blocks, blocks_next;
  logic [4:0]  pos, pos_next;
  logic [31:0] sender, sender_next;
  logic [63:0] shift [3];
  logic [63:0] shift_next [3];

  result_t     fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic        accept, pop;
  logic [1:0]  push_n;
  result_t     res_a, res_b;
  result_t     head;

  logic        run, blk_hit, end_hit;
  logic [11:0] len;
  logic [18:0] rl, rr_min;
  result_t     blk_res, end_res;
  status_t     end_st;

  assign accept    = pkt.valid && pkt.ready;
  assign pop       = rpt.valid && rpt.ready;
  assign pkt.ready = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    mode_next   = mode;
    stop_next   = stop;
    left_next   = left;
    bis_next    = bis;
    splen_next  = splen;
    sptype_next = sptype;
    blocks_next = blocks;
    pos_next    = pos;
    sender_next = sender;
    for (int i = 0; i < 3; i++) begin
      shift_next[i] = shift[i];
    end
    run     = 1'b0;
    blk_hit = 1'b0;
    end_hit = 1'b0;
    len     = pkt.packet_len;
    rl      = '0;
    rr_min  = '0;
    blk_res = '0;
    end_res = '0;
    end_st  = ST_OK;

    if (accept) begin
      run = 1'b1;
      if (pkt.first_byte) begin
        if (len > 12'(MAX_PACKET_BYTES)) begin
          len = 12'(MAX_PACKET_BYTES);
        end
        if (len == 12'd0) begin
          len = 12'd1;
        end
        left_next   = len;
        bis_next    = '0;
        splen_next  = '0;
        sptype_next = '0;
        blocks_next = '0;
        stop_next   = ST_OK;
        mode_next   = MODE_HDR;
        if (len < 12'd8) begin
          stop_next = ST_SHORT;
          mode_next = MODE_STOP;
        end
      end else if (mode == MODE_IDLE) begin
        run = 1'b0;
      end

      if (run) begin
        unique case (mode_next)
          MODE_HDR: begin
            case (bis_next[1:0])
              2'd0: begin
                if (pkt.data_byte[7:6] != RTP_VERSION) begin
                  stop_next = ST_VERSION;
                  mode_next = MODE_STOP;
                end else begin
                  blocks_next = pkt.data_byte[4:0];
                  bis_next    = bis_next + 19'd1;
                end
              end
              2'd1: begin
                sptype_next = pkt.data_byte;
                bis_next    = bis_next + 19'd1;
              end
              2'd2: begin
                splen_next = {3'b000, pkt.data_byte, 8'h00};
                bis_next   = bis_next + 19'd1;
              end
              default: begin
                rl     = 19'({splen_next[15:8], pkt.data_byte, 2'b00}) + 19'd4;
                rr_min = 19'({blocks_next, 4'b0000}) + 19'({blocks_next, 3'b000}) + 19'd8;
                if (rl < 19'd8 || rl > 19'(left_next) + 19'd3) begin
                  stop_next = ST_SHORT;
                  mode_next = MODE_STOP;
                end else if (sptype_next == TYPE_RR && rl < rr_min) begin
                  stop_next = ST_SHORT;
                  mode_next = MODE_STOP;
                end else if (sptype_next != TYPE_RR && sptype_next != TYPE_SR &&
                             sptype_next != TYPE_SDES && sptype_next != TYPE_BYE) begin
                  stop_next = ST_TYPE;
                  mode_next = MODE_STOP;
                end else begin
                  splen_next = rl;
                  mode_next  = MODE_BODY;
                  pos_next   = '0;
                  bis_next   = bis_next + 19'd1;
                end
              end
            endcase
          end
          MODE_BODY: begin
            if (bis_next < 19'd8) begin
              sender_next = {sender_next[23:0], pkt.data_byte};
            end else if (sptype_next == TYPE_RR && blocks_next != 5'd0) begin
              for (int i = 0; i < 3; i++) begin
                if (pos_next[4:3] == 2'(i)) begin
                  shift_next[i] = {shift[i][55:0], pkt.data_byte};
                end
              end
              if (pos_next == 5'd23) begin
                blk_hit                 = 1'b1;
                blk_res.kind            = KIND_BLOCK;
                blk_res.status          = ST_OK;
                blk_res.reporter_ssrc   = sender_next;
                blk_res.source_ssrc     = shift_next[0][63:32];
                blk_res.loss_fraction   = shift_next[0][31:24];
                blk_res.cumulative_lost = shift_next[0][23:0];
                blk_res.highest_seq     = shift_next[1][63:32];
                blk_res.jitter          = shift_next[1][31:0];
                blk_res.last_sr         = shift_next[2][63:32];
                blk_res.delay_since_sr  = shift_next[2][31:0];
                blocks_next             = blocks_next - 5'd1;
                pos_next                = '0;
              end else begin
                pos_next = pos_next + 5'd1;
              end
            end
            bis_next = bis_next + 19'd1;
            if (bis_next >= splen_next) begin
              mode_next = MODE_HDR;
              bis_next  = '0;
            end
          end
          default: begin
          end
        endcase

        left_next = left_next - 12'd1;
        if (left_next == 12'd0) begin
          end_hit = 1'b1;
          end_st  = stop_next;
          if (mode_next == MODE_HDR && bis_next != 19'd0) begin
            end_st = ST_SHORT;
          end
          if (mode_next == MODE_BODY) begin
            end_st = ST_SHORT;
          end
          end_res.kind   = KIND_STATUS;
          end_res.status = end_st;
          mode_next      = MODE_IDLE;
          bis_next       = '0;
        end
      end
    end

    push_n = 2'({1'b0, blk_hit}) + 2'({1'b0, end_hit});
    res_a  = blk_hit ? blk_res : end_res;
    res_b  = end_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      stop   <= ST_OK;
      left   <= '0;
      bis    <= '0;
      splen  <= '0;
      sptype <= '0;
      blocks <= '0;
      pos    <= '0;
    end else begin
      mode   <= mode_next;
      stop   <= stop_next;
      left   <= left_next;
      bis    <= bis_next;
      splen  <= splen_next;
      sptype <= sptype_next;
      blocks <= blocks_next;
      pos    <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sender <= '0;
      for (int i = 0; i < 3; i++) begin
        shift[i] <= '0;
      end
    end else begin
      sender <= sender_next;
      for (int i = 0; i < 3; i++) begin
        shift[i] <= shift_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[wr_ptr] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo[wr_ptr + PTR_W'(1)] <= res_b;
    end
  end

  assign head                = fifo[rd_ptr];
  assign rpt.valid           = (count != '0);
  assign rpt.kind            = head.kind;
  assign rpt.status          = head.status;
  assign rpt.reporter_ssrc   = head.reporter_ssrc;
  assign rpt.source_ssrc     = head.source_ssrc;
  assign rpt.loss_fraction   = head.loss_fraction;
  assign rpt.cumulative_lost = head.cumulative_lost;
  assign rpt.highest_seq     = head.highest_seq;
  assign rpt.jitter          = head.jitter;
  assign rpt.last_sr         = head.last_sr;
  assign rpt.delay_since_sr  = head.delay_since_sr;

endmodule
`default_nettype wire

// ===== bench/rtcp_report_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP report checker
// Watches the byte and report channels of the receiver report parser. Every
// accepted byte beat is run through a behavioural copy of the datagram walker,
// which queues the report blocks and status results it should produce. Every
// accepted report beat is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module rtcp_report_checker (
  input  logic        clk,
  input  logic        rst,
  rtcp_byte_if        pkt,
  rtcp_report_if      rpt,
  output int unsigned mismatch_count,
  output int unsigned reports_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import rtcprr_pkg::*;

  mode_t       mode;
  logic [11:0] bytes_left;
  logic [18:0] byte_pos;
  logic [18:0] sub_len;
  logic [7:0]  sub_type;
  logic [4:0]  blocks_left;
  logic [31:0] hdr_ssrc;
  logic [63:0] block_words [3];
  status_t     stop_st;

  result_t     expected_reports [$];
  bit          field_bad;

  task automatic halt_parse(input status_t st);
    stop_st = st;
    mode    = MODE_STOP;
  endtask

  task automatic parse_header(input logic [7:0] b);
    int unsigned rl;
    case (byte_pos)
      0: begin
        if (b[7:6] != RTP_VERSION) begin
          halt_parse(ST_VERSION);
          return;
        end
        blocks_left = b[4:0];
      end
      1: sub_type = b;
      2: sub_len = {3'b000, b, 8'h00};
      default: begin
        sub_len = sub_len | b;
        rl = sub_len * 4 + 4;
        if (rl < 8 || rl > bytes_left + 3) begin
          halt_parse(ST_SHORT);
          return;
        end
        if (sub_type == TYPE_RR) begin
          if (rl < 8 + 24 * blocks_left) begin
            halt_parse(ST_SHORT);
            return;
          end
        end else if (sub_type != TYPE_SR && sub_type != TYPE_SDES && sub_type != TYPE_BYE) begin
          halt_parse(ST_TYPE);
          return;
        end
        sub_len = rl[18:0];
        mode    = MODE_BODY;
      end
    endcase
    byte_pos++;
  endtask

  task automatic parse_body(input logic [7:0] b);
    int unsigned p;
    result_t     res;
    if (byte_pos < 8) begin
      hdr_ssrc = {hdr_ssrc[23:0], b};
    end else if (sub_type == TYPE_RR && blocks_left != 0) begin
      p = (byte_pos - 8) % 24;
      block_words[p / 8] = {block_words[p / 8][55:0], b};
      if (p == 23) begin
        res                 = '0;
        res.kind            = KIND_BLOCK;
        res.status          = ST_OK;
        res.reporter_ssrc   = hdr_ssrc;
        res.source_ssrc     = block_words[0][63:32];
        res.loss_fraction   = block_words[0][31:24];
        res.cumulative_lost = block_words[0][23:0];
        res.highest_seq     = block_words[1][63:32];
        res.jitter          = block_words[1][31:0];
        res.last_sr         = block_words[2][63:32];
        res.delay_since_sr  = block_words[2][31:0];
        expected_reports.push_back(res);
        blocks_left--;
      end
    end
    byte_pos++;
    if (byte_pos >= sub_len) begin
      mode     = MODE_HDR;
      byte_pos = 0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first, input logic [11:0] plen);
    int unsigned len;
    result_t     res;
    if (first) begin
      len = plen;
      if (len > MAX_PACKET_BYTES) len = MAX_PACKET_BYTES;
      if (len == 0) len = 1;
      bytes_left  = len[11:0];
      byte_pos    = 0;
      sub_len     = 0;
      sub_type    = 0;
      blocks_left = 0;
      stop_st     = ST_OK;
      mode        = MODE_HDR;
      if (len < 8) halt_parse(ST_SHORT);
    end else if (mode == MODE_IDLE) begin
      return;
    end
    if (mode == MODE_HDR) begin
      parse_header(b);
    end else if (mode == MODE_BODY) begin
      parse_body(b);
    end
    bytes_left--;
    if (bytes_left == 0) begin
      res        = '0;
      res.kind   = KIND_STATUS;
      res.status = stop_st;
      if (mode == MODE_HDR && byte_pos != 0) res.status = ST_SHORT;
      if (mode == MODE_BODY) res.status = ST_SHORT;
      expected_reports.push_back(res);
      mode     = MODE_IDLE;
      byte_pos = 0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      if (mismatch_count < 10) begin
        $display("report beat mismatch in %s: expected %h, got %h", name, want, got);
      end
      field_bad = 1'b1;
    end
  endtask

  task automatic check_report();
    result_t want;
    if (expected_reports.size() == 0) begin
      if (mismatch_count < 10) begin
        $display("report beat with nothing expected: kind %b status %b source %h",
                 rpt.kind, rpt.status, rpt.source_ssrc);
      end
      mismatch_count++;
      return;
    end
    want      = expected_reports.pop_front();
    field_bad = 1'b0;
    compare_field("kind", want.kind, rpt.kind);
    compare_field("status", want.status, rpt.status);
    compare_field("reporter_ssrc", want.reporter_ssrc, rpt.reporter_ssrc);
    compare_field("source_ssrc", want.source_ssrc, rpt.source_ssrc);
    compare_field("loss_fraction", want.loss_fraction, rpt.loss_fraction);
    compare_field("cumulative_lost", want.cumulative_lost, rpt.cumulative_lost);
    compare_field("highest_seq", want.highest_seq, rpt.highest_seq);
    compare_field("jitter", want.jitter, rpt.jitter);
    compare_field("last_sr", want.last_sr, rpt.last_sr);
    compare_field("delay_since_sr", want.delay_since_sr, rpt.delay_since_sr);
    if (field_bad) mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode           = MODE_IDLE;
      bytes_left     = 0;
      byte_pos       = 0;
      sub_len        = 0;
      sub_type       = 0;
      blocks_left    = 0;
      hdr_ssrc       = 0;
      foreach (block_words[w]) block_words[w] = 0;
      stop_st        = ST_OK;
      mismatch_count = 0;
      expected_reports.delete();
    end else begin
      if (pkt.valid === 1'b1 && pkt.ready === 1'b1) begin
        parse_byte(pkt.data_byte, pkt.first_byte, pkt.packet_len);
      end
      if (rpt.valid === 1'b1 && rpt.ready === 1'b1) begin
        check_report();
      end
    end
    reports_pending = expected_reports.size();
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RTCP receiver report parser testbench
// Feeds compound RTCP datagrams byte by byte: a directed set covering tiny and
// clamped lengths, every sub-packet type and every stop condition, then random
// compound datagrams mixed with truncated, restarted, corrupted and noise
// traffic. The sender idles in bursts, the receiver stalls on its own pattern
// and once holds off long enough to back the parser up. A separate checker
// predicts and compares every report beat.
// ----------------------------------------------------------------------------
module tb;

  import rtcprr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtcp_byte_if   pkt ();
  rtcp_report_if rpt ();

  int unsigned mismatch_count;
  int unsigned reports_pending;

  rtcp_receiver_report_parser i_dut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt),
    .rpt (rpt)
  );

  rtcp_report_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .pkt             (pkt),
    .rpt             (rpt),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  logic [7:0]  dgram [$];
  logic [7:0]  odd_types [4] = '{8'd0, 8'd199, 8'd204, 8'd255};
  int unsigned burst_left    = 0;
  int unsigned bytes_offered = 0;
  int unsigned cycle_count   = 0;
  bit          hold_request  = 1'b0;
  bit          hold_served   = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned stall_mode    = 0;
  int unsigned phase_left    = 0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic add_header(input logic [1:0] ver, input logic [4:0] count,
                            input logic [7:0] ptype, input logic [15:0] words);
    dgram.push_back({ver, 1'($urandom_range(0, 1)), count});
    dgram.push_back(ptype);
    dgram.push_back(words[15:8]);
    dgram.push_back(words[7:0]);
  endtask

  task automatic add_bytes(input int n, input int fill);
    repeat (n) dgram.push_back(fill < 0 ? 8'($urandom) : fill[7:0]);
  endtask

  task automatic add_rr(input int blocks, input int slack, input int fill);
    add_header(2'd2, 5'(blocks), TYPE_RR, 16'(1 + 6 * blocks + slack));
    add_bytes(4 + 24 * blocks + 4 * slack, fill);
  endtask

  task automatic add_other(input logic [7:0] ptype, input int words);
    add_header(2'd2, 5'($urandom_range(0, 31)), ptype, 16'(words));
    add_bytes(4 * words, -1);
  endtask

  task automatic build_compound();
    int unsigned nsub;
    logic [7:0]  ptype;
    nsub = $urandom_range(1, 3);
    repeat (nsub) begin
      if ($urandom_range(0, 1) == 1) begin
        add_rr($urandom_range(0, 3), ($urandom_range(0, 4) == 0) ? 1 : 0, -1);
      end else begin
        case ($urandom_range(0, 2))
          0:       ptype = TYPE_SR;
          1:       ptype = TYPE_SDES;
          default: ptype = TYPE_BYE;
        endcase
        add_other(ptype, $urandom_range(1, 7));
      end
    end
  endtask

  task automatic send_beat(input logic [7:0] d, input logic first, input logic [11:0] plen);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pkt.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    pkt.valid      <= 1'b1;
    pkt.data_byte  <= d;
    pkt.first_byte <= first;
    pkt.packet_len <= plen;
    do @(posedge clk); while (pkt.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_dgram(input int unsigned declared, input int unsigned beats);
    logic [7:0] d;
    for (int unsigned i = 0; i < beats; i++) begin
      d = (i < dgram.size()) ? dgram[i] : 8'($urandom);
      send_beat(d, i == 0, (i == 0) ? declared[11:0] : 12'($urandom));
    end
    bytes_offered += beats;
    dgram.delete();
  endtask

  task automatic send_whole();
    send_dgram(dgram.size(), dgram.size());
  endtask

  task automatic send_strays(input int unsigned n);
    repeat (n) send_beat(8'($urandom), 1'b0, 12'($urandom));
  endtask

  initial begin
    rpt.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        hold_left   = HOLD_CYCLES;
        hold_served = 1'b1;
      end
      if (hold_left != 0) begin
        rpt.ready <= 1'b0;
        hold_left--;
      end else begin
        if (phase_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        case (stall_mode)
          0:       rpt.ready <= 1'b1;
          1:       rpt.ready <= 1'($urandom_range(0, 1));
          2:       rpt.ready <= ($urandom_range(0, 7) == 0);
          default: rpt.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned choice;
    int unsigned start;
    int          declared;
    pkt.valid      = 1'b0;
    pkt.data_byte  = 8'h00;
    pkt.first_byte = 1'b0;
    pkt.packet_len = 12'h000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_strays(3);
    add_bytes(1, -1);
    send_dgram(1, 1);
    add_bytes(1, -1);
    send_dgram(0, 1);
    add_rr(0, 0, -1);
    send_dgram(7, 7);
    add_rr(1, 0, -1);
    send_whole();
    add_rr(0, 0, -1);
    send_whole();
    add_rr(2, 0, 8'h00);
    send_whole();
    add_rr(2, 2, 8'hFF);
    send_whole();
    add_other(TYPE_SR, 12);
    add_rr(2, 1, -1);
    add_other(TYPE_SDES, 3);
    add_other(TYPE_BYE, 1);
    send_whole();
    send_strays(2);

    add_header(2'd1, 5'd0, TYPE_RR, 16'd1);
    add_bytes(4, -1);
    send_whole();
    add_header(2'd3, 5'd31, TYPE_RR, 16'hFFFF);
    add_bytes(4, -1);
    send_whole();
    add_header(2'd2, 5'd0, TYPE_SR, 16'd0);
    add_bytes(8, -1);
    send_whole();
    add_header(2'd2, 5'd0, TYPE_SDES, 16'd10);
    add_bytes(8, -1);
    send_whole();
    add_header(2'd2, 5'd0, TYPE_BYE, 16'hFFFF);
    add_bytes(4, -1);
    send_whole();
    add_header(2'd2, 5'd2, TYPE_RR, 16'd6);
    add_bytes(24, -1);
    send_whole();
    foreach (odd_types[k]) begin
      add_header(2'd2, 5'd0, odd_types[k], 16'd1);
      add_bytes(4, -1);
      send_whole();
    end
    add_rr(0, 0, -1);
    add_header(2'd2, 5'd0, TYPE_RR, 16'd1);
    send_dgram(10, 10);
    add_rr(1, 0, -1);
    send_dgram(20, dgram.size());

    add_rr(2, 0, -1);
    send_dgram(dgram.size(), 20);
    add_header(2'd0, 5'd0, TYPE_RR, 16'd1);
    add_bytes(4, -1);
    send_dgram(8, 3);
    add_rr(1, 1, -1);
    send_whole();

    add_header(2'd2, 5'd1, TYPE_RR, 16'd511);
    add_bytes(28, -1);
    send_dgram(2049, 32);
    add_header(2'd2, 5'd1, TYPE_RR, 16'd512);
    add_bytes(28, -1);
    send_dgram(4095, 32);

    hold_request = 1'b1;
    start = bytes_offered;
    while (bytes_offered - start < 520) begin
      choice = $urandom_range(0, 9);
      if (choice < 9) build_compound();
      case (choice)
        6: begin
          dgram[$urandom_range(0, dgram.size() - 1)] = 8'($urandom);
          send_whole();
        end
        7: send_dgram(dgram.size(), $urandom_range(1, dgram.size() - 1));
        8: begin
          declared = int'(dgram.size()) + $urandom_range(0, 12) - 6;
          send_dgram(declared, dgram.size());
          send_strays($urandom_range(0, 2));
        end
        9: begin
          add_bytes($urandom_range(1, 40), -1);
          send_dgram($urandom_range(1, 48), dgram.size());
        end
        default: send_whole();
      endcase
    end
    pkt.valid <= 1'b0;

    while (reports_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
